// ===== design/alle_pkg.sv =====
// Shared types, constants and helpers for the array linked list engine.
package alle_pkg;

  localparam int CAP      = 256;
  localparam int SW       = $clog2(CAP);
  localparam int PW       = SW + 1;
  localparam int KEY_BITS = 32;

  localparam logic [PW-1:0] NONE_SLOT = PW'(CAP);

  localparam logic [2:0] F_APPEND = 3'd0;
  localparam logic [2:0] F_INS_BEF = 3'd1;
  localparam logic [2:0] F_INS_AFT = 3'd2;
  localparam logic [2:0] F_DELETE = 3'd3;
  localparam logic [2:0] F_FIND   = 3'd4;
  localparam logic [2:0] F_READ   = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_BADREF   = 2'd3;

  localparam logic [2:0] RS_NONE = 3'd0;
  localparam logic [2:0] RS_FREE = 3'd1;
  localparam logic [2:0] RS_REF  = 3'd2;
  localparam logic [2:0] RS_HEAD = 3'd3;
  localparam logic [2:0] RS_NEXT = 3'd4;
  localparam logic [2:0] RS_SLOT = 3'd5;

  localparam logic [1:0] RES_NONE = 2'd0;
  localparam logic [1:0] RES_FAIL = 2'd1;
  localparam logic [1:0] RES_RD   = 2'd2;

  typedef struct packed {
    logic [2:0]          func;
    logic [7:0]          ref_slot;
    logic [KEY_BITS-1:0] entry_key;
    logic [31:0]         entry_value;
    logic [2:0]          entry_kind;
  } in_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [8:0]          slot;
    logic [KEY_BITS-1:0] found_key;
    logic [31:0]         found_value;
    logic [2:0]          found_kind;
    logic [8:0]          next_slot;
    logic [8:0]          prev_slot;
    logic [8:0]          first_slot;
    logic [8:0]          last_slot;
    logic [8:0]          entry_count;
  } out_t;

  typedef struct packed {
    logic       latch;
    logic [2:0] rd_sel;
    logic       cap_pop;
    logic       alloc;
    logic       link2;
    logic       hold_hit;
    logic       unlink1;
    logic       unlink2;
    logic [1:0] res;
    logic [1:0] res_status;
    logic       fire;
  } cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       full;
    logic       ref_ok;
    logic       head_none;
    logic       hit;
    logic       rd_next_none;
  } sts_t;

  function automatic logic slot_ok(input logic [PW-1:0] s);
    return s < PW'(CAP);
  endfunction

endpackage

// ===== design/alle_ctrl.sv =====
// Sequencer for the list engine: decodes a request into datapath steps.
module alle_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  alle_pkg::sts_t sts,
  output alle_pkg::cmd_t cmd
);
  import alle_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHECK  = 4'd1;
  localparam logic [3:0] S_A_POP  = 4'd2;
  localparam logic [3:0] S_A_WR   = 4'd3;
  localparam logic [3:0] S_A_LINK = 4'd4;
  localparam logic [3:0] S_REPORT = 4'd5;
  localparam logic [3:0] S_SEARCH = 4'd6;
  localparam logic [3:0] S_U1     = 4'd7;
  localparam logic [3:0] S_U2     = 4'd8;

  logic [3:0] state_r, state_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        state_nxt = S_IDLE;
        unique case (sts.func)
          F_APPEND, F_INS_BEF, F_INS_AFT: begin
            if (sts.func != F_APPEND && !sts.ref_ok) begin
              cmd.res = RES_FAIL; cmd.res_status = ST_BADREF; cmd.fire = 1'b1;
            end else if (sts.full) begin
              cmd.res = RES_FAIL; cmd.res_status = ST_FULL; cmd.fire = 1'b1;
            end else begin
              cmd.rd_sel = RS_FREE;
              state_nxt = S_A_POP;
            end
          end
          F_DELETE, F_FIND: begin
            if (sts.head_none) begin
              cmd.res = RES_FAIL; cmd.res_status = ST_NOTFOUND; cmd.fire = 1'b1;
            end else begin
              cmd.rd_sel = RS_HEAD;
              state_nxt = S_SEARCH;
            end
          end
          F_READ: begin
            if (!sts.ref_ok) begin
              cmd.res = RES_FAIL; cmd.res_status = ST_BADREF; cmd.fire = 1'b1;
            end else begin
              cmd.rd_sel = RS_REF;
              state_nxt = S_REPORT;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_A_POP: begin
        cmd.cap_pop = 1'b1;
        cmd.rd_sel = RS_REF;
        state_nxt = S_A_WR;
      end
      S_A_WR: begin
        cmd.alloc = 1'b1;
        state_nxt = S_A_LINK;
      end
      S_A_LINK: begin
        cmd.link2 = 1'b1;
        cmd.rd_sel = RS_SLOT;
        state_nxt = S_REPORT;
      end
      S_REPORT: begin
        cmd.res = RES_RD; cmd.res_status = ST_OK; cmd.fire = 1'b1;
        state_nxt = S_IDLE;
      end
      S_SEARCH: begin
        if (sts.hit) begin
          cmd.res = RES_RD; cmd.res_status = ST_OK;
          if (sts.func == F_DELETE) begin
            cmd.hold_hit = 1'b1;
            state_nxt = S_U1;
          end else begin
            cmd.fire = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (sts.rd_next_none) begin
          cmd.res = RES_FAIL; cmd.res_status = ST_NOTFOUND; cmd.fire = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.rd_sel = RS_NEXT;
        end
      end
      S_U1: begin
        cmd.unlink1 = 1'b1;
        state_nxt = S_U2;
      end
      S_U2: begin
        cmd.unlink2 = 1'b1;
        cmd.fire = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== design/alle_dp.sv =====
// Datapath of the list engine: slot memories, list registers, free chain and result.
module alle_dp (
  input  logic           clk,
  input  logic           rst_n,
  input  alle_pkg::in_t  in_req,
  input  alle_pkg::cmd_t cmd,
  output alle_pkg::sts_t sts,
  output logic           out_valid,
  output alle_pkg::out_t out_res
);
  import alle_pkg::*;

  typedef struct packed {
    logic [1:0]          status;
    logic [PW-1:0]       slot;
    logic [KEY_BITS-1:0] key;
    logic [31:0]         value;
    logic [2:0]          kind;
    logic [PW-1:0]       nxt;
    logic [PW-1:0]       prv;
  } info_t;

  logic [KEY_BITS-1:0] key_mem  [CAP];
  logic [31:0]         val_mem  [CAP];
  logic [2:0]          kind_mem [CAP];
  logic [PW-1:0]       next_mem [CAP];
  logic [PW-1:0]       prev_mem [CAP];

  logic [CAP-1:0]      in_use_r;
  in_t                 req_r;
  logic [PW-1:0]       head_r, tail_r, count_r, rec_r, fresh_r, pop_r, rn_r, rp_r;
  logic [SW-1:0]       s_r, cur_r;
  info_t               info_r;
  logic                out_valid_r;

  logic [KEY_BITS-1:0] rd_key;
  logic [31:0]         rd_val;
  logic [2:0]          rd_kind;
  logic [PW-1:0]       rd_next, rd_prev;

  logic [SW-1:0]       ref_idx, fs, rd_addr;
  logic                from_rec, rd_en;
  logic                wn_en, wp_en;
  logic [SW-1:0]       wn_addr, wp_addr;
  logic [PW-1:0]       wn_data, wp_data;
  logic [PW-1:0]       new_next, new_prev;

  assign ref_idx  = SW'(req_r.ref_slot);
  assign from_rec = slot_ok(rec_r);
  assign fs       = from_rec ? rec_r[SW-1:0] : fresh_r[SW-1:0];

  assign sts.func         = req_r.func;
  assign sts.full         = (count_r == PW'(CAP));
  assign sts.ref_ok       = ({1'b0, req_r.ref_slot} < 9'(CAP)) && in_use_r[ref_idx];
  assign sts.head_none    = !slot_ok(head_r);
  assign sts.hit          = (rd_key == req_r.entry_key);
  assign sts.rd_next_none = !slot_ok(rd_next);

  // read address select
  always_comb begin
    rd_en = 1'b1;
    unique case (cmd.rd_sel)
      RS_FREE: rd_addr = rec_r[SW-1:0];
      RS_REF:  rd_addr = ref_idx;
      RS_HEAD: rd_addr = head_r[SW-1:0];
      RS_NEXT: rd_addr = rd_next[SW-1:0];
      RS_SLOT: rd_addr = s_r;
      default: begin
        rd_addr = '0;
        rd_en   = 1'b0;
      end
    endcase
  end

  // links of the new slot
  always_comb begin
    unique case (req_r.func)
      F_INS_BEF: begin
        new_next = {1'b0, ref_idx};
        new_prev = rd_prev;
      end
      F_INS_AFT: begin
        new_next = rd_next;
        new_prev = {1'b0, ref_idx};
      end
      default: begin
        new_next = NONE_SLOT;
        new_prev = tail_r;
      end
    endcase
  end

  // link write ports
  always_comb begin
    wn_en = 1'b0; wn_addr = '0; wn_data = '0;
    wp_en = 1'b0; wp_addr = '0; wp_data = '0;
    if (cmd.alloc) begin
      wn_en = 1'b1; wn_addr = fs; wn_data = new_next;
      wp_en = 1'b1; wp_addr = fs; wp_data = new_prev;
    end else if (cmd.link2) begin
      if (req_r.func == F_INS_AFT) begin
        wn_en = 1'b1; wn_addr = ref_idx; wn_data = {1'b0, s_r};
        wp_en = slot_ok(rn_r); wp_addr = rn_r[SW-1:0]; wp_data = {1'b0, s_r};
      end else begin
        wn_en = slot_ok(rp_r); wn_addr = rp_r[SW-1:0]; wn_data = {1'b0, s_r};
        wp_en = (req_r.func == F_INS_BEF); wp_addr = ref_idx; wp_data = {1'b0, s_r};
      end
    end else if (cmd.unlink1) begin
      wn_en = slot_ok(rp_r); wn_addr = rp_r[SW-1:0]; wn_data = rn_r;
      wp_en = slot_ok(rn_r); wp_addr = rn_r[SW-1:0]; wp_data = rp_r;
    end else if (cmd.unlink2) begin
      wn_en = 1'b1; wn_addr = s_r; wn_data = rec_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.alloc) begin
      key_mem[fs]  <= req_r.entry_key;
      val_mem[fs]  <= req_r.entry_value;
      kind_mem[fs] <= req_r.entry_kind;
    end
    if (wn_en) next_mem[wn_addr] <= wn_data;
    if (wp_en) prev_mem[wp_addr] <= wp_data;
    if (rd_en) begin
      rd_key  <= key_mem[rd_addr];
      rd_val  <= val_mem[rd_addr];
      rd_kind <= kind_mem[rd_addr];
      rd_next <= next_mem[rd_addr];
      rd_prev <= prev_mem[rd_addr];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) req_r <= in_req;
    if (cmd.cap_pop) pop_r <= rd_next;
    if (rd_en) cur_r <= rd_addr;
    if (cmd.alloc) begin
      s_r  <= fs;
      rn_r <= rd_next;
      rp_r <= (req_r.func == F_APPEND) ? tail_r : rd_prev;
    end
    if (cmd.hold_hit) begin
      s_r  <= cur_r;
      rn_r <= rd_next;
      rp_r <= rd_prev;
    end
    unique case (cmd.res)
      RES_FAIL: info_r <= '{status: cmd.res_status, slot: NONE_SLOT, key: '0, value: '0,
                            kind: '0, nxt: NONE_SLOT, prv: NONE_SLOT};
      RES_RD:   info_r <= '{status: cmd.res_status, slot: {1'b0, cur_r}, key: rd_key,
                            value: rd_val, kind: rd_kind, nxt: rd_next, prv: rd_prev};
      default:  info_r <= info_r;
    endcase
  end

  // list control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= NONE_SLOT;
      tail_r      <= NONE_SLOT;
      count_r     <= '0;
      rec_r       <= NONE_SLOT;
      fresh_r     <= '0;
      in_use_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.fire;
      if (cmd.alloc) begin
        in_use_r[fs] <= 1'b1;
        count_r      <= count_r + 1'b1;
        if (from_rec) rec_r <= pop_r;
        else          fresh_r <= fresh_r + 1'b1;
        unique case (req_r.func)
          F_INS_BEF: if (!slot_ok(rd_prev)) head_r <= {1'b0, fs};
          F_INS_AFT: if (!slot_ok(rd_next)) tail_r <= {1'b0, fs};
          default: begin
            if (!slot_ok(tail_r)) head_r <= {1'b0, fs};
            tail_r <= {1'b0, fs};
          end
        endcase
      end
      if (cmd.unlink1) begin
        if (!slot_ok(rp_r)) head_r <= rn_r;
        if (!slot_ok(rn_r)) tail_r <= rp_r;
      end
      if (cmd.unlink2) begin
        rec_r         <= {1'b0, s_r};
        in_use_r[s_r] <= 1'b0;
        count_r       <= count_r - 1'b1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_res = '{status: info_r.status, slot: 9'(info_r.slot), found_key: info_r.key,
                     found_value: info_r.value, found_kind: info_r.kind,
                     next_slot: 9'(info_r.nxt), prev_slot: 9'(info_r.prv),
                     first_slot: 9'(head_r), last_slot: 9'(tail_r),
                     entry_count: 9'(count_r)};

endmodule

// ===== design/array_linked_list_engine_core.sv =====
// Top level of the array linked list engine: sequencer plus datapath.
//
// A pool of slots holds one doubly linked list; unused slots form a free chain.
// Input channel: drive in_req and raise start; the transaction is taken at a
// rising edge where start is high and busy is low. busy stays high until the
// request is done. Requests: append, insert before/after a slot, delete by key,
// find by key, read slot. Unused function codes finish without a result.
// Result channel: out_valid is high for exactly one cycle with out_res; the
// receiver cannot stall, so it must take the transaction in that cycle.
// out_res also carries head, tail and entry count after the request.
// Find and delete walk the list from the head, comparing keys until a match
// or the end of the list. The key walk reads one slot per cycle through the
// registered read port of the slot memories. One request is in flight at a
// time; the next one can be taken at the edge that takes the result.
// Reset (rst_n low, synchronous) empties the list and rebuilds the free chain
// at once: fresh slots are handed out in order by a fill pointer, so no
// clearing pass is needed and the block accepts a request right after reset.
module array_linked_list_engine_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  alle_pkg::in_t  in_req,
  output logic           out_valid,
  output alle_pkg::out_t out_res
);
  import alle_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: one state per datapath step
  alle_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // datapath: memories, list pointers, free chain, result register
  alle_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

endmodule

// ===== design/alle_checker.sv =====
// Port-level checks for the list engine, bound to the top level.
module alle_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input logic           out_valid,
  input alle_pkg::out_t out_res
);
  import alle_pkg::*;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy not raised after accept");

  a_single_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  a_fail_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.status != ST_OK |-> out_res.slot == 9'(CAP))
    else $error("failed result reports a slot");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_res.entry_count <= 9'(CAP)) else $error("entry count out of range");

  a_empty_list: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.entry_count == 9'd0 |-> out_res.first_slot == 9'(CAP))
    else $error("empty list reports a head");

endmodule

bind array_linked_list_engine_core alle_checker u_alle_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_res   (out_res)
);
